FILE: design/assert_macros.svh
// Assertion helpers included by haft_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must bring a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must bring a consequence in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/haft_pkg.sv
package haft_pkg;

  // Default table depth.
  localparam int TABLE_ENTRIES_DEFAULT = 16;

  // Item modes.
  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // Result status codes.
  localparam logic [2:0] STATUS_HIT    = 3'd0;
  localparam logic [2:0] STATUS_INSERT = 3'd1;
  localparam logic [2:0] STATUS_DROP   = 3'd2;
  localparam logic [2:0] STATUS_IGNORE = 3'd3;
  localparam logic [2:0] STATUS_CLEAR  = 3'd4;
  localparam logic [2:0] STATUS_READ   = 3'd5;

  // Hit counts stop at this value.
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // One table entry.
  typedef struct packed {
    logic [31:0] addr;
    logic        isa;
    logic [31:0] count;
  } entry_t;

  // What every cell does in the current cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CAPTURE,
    CELL_MOVE,
    CELL_INSERT,
    CELL_CLEAR
  } cell_op_t;

  // Broadcast from the controller to the row of cells.
  typedef struct packed {
    cell_op_t    op;
    logic [31:0] addr;
    logic        isa;
    logic [31:0] count;
  } cell_ctrl_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    entry_t entry;
    logic   valid;
    logic   grp;
  } cell_link_t;

  // Per-cell status seen by the controller.
  typedef struct packed {
    logic match;
    logic first;
  } cell_flags_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FINISH
  } state_t;

endpackage

FILE: design/haft_cell.sv
module haft_cell #(
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      idx,
  input  logic [IDX_W-1:0]      hit_idx,
  input  haft_pkg::cell_ctrl_t  ctrl,
  input  haft_pkg::cell_link_t  left,
  output haft_pkg::cell_link_t  right,
  output haft_pkg::cell_flags_t flags
);
  import haft_pkg::*;

  entry_t entry;
  logic   valid;
  logic   match;
  logic   grp;
  logic   first;
  logic   free_first;

  // A cell joins the moving group when it sits at or above the hit and its
  // count falls below the hit's new count; the group's top cell takes the hit.
  always_comb begin
    grp        = (ctrl.op == CELL_MOVE) && valid && (idx <= hit_idx) &&
                 (entry.count < ctrl.count);
    first      = grp && !left.grp;
    free_first = !valid && left.valid;
    right      = '{entry: entry, valid: valid, grp: grp};
    flags      = '{match: match, first: first};
  end

  // Valid bit and registered address match.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_CAPTURE: begin
          match <= valid && (entry.addr == ctrl.addr) && (entry.isa == ctrl.isa);
        end
        CELL_INSERT: begin
          if (free_first) begin
            valid <= 1'b1;
          end
        end
        CELL_CLEAR: begin
          valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Entry contents: load the hit, shift down from the left, or append.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_MOVE: begin
        if (first) begin
          entry <= '{addr: ctrl.addr, isa: ctrl.isa, count: ctrl.count};
        end else if (grp) begin
          entry <= left.entry;
        end
      end
      CELL_INSERT: begin
        if (free_first) begin
          entry <= '{addr: ctrl.addr, isa: ctrl.isa, count: ctrl.count};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/haft_pick.sv
module haft_pick #(
  parameter int TABLE_ENTRIES = 16,
  parameter int IDX_W         = 4
) (
  input  logic [TABLE_ENTRIES-1:0] sel,
  input  haft_pkg::entry_t         entries [TABLE_ENTRIES],
  output haft_pkg::entry_t         entry,
  output logic [IDX_W-1:0]         idx,
  output logic                     any
);
  import haft_pkg::*;

  // One-hot select: OR together the chosen entry and its position.
  always_comb begin
    entry = '0;
    idx   = '0;
    any   = |sel;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (sel[k]) begin
        entry = entry | entries[k];
        idx   = idx | IDX_W'(k);
      end
    end
  end

endmodule

FILE: design/hot_address_frequency_table.sv
// A record or read word is compared in all cells at the accepting edge,
// selected across the row, and then the row is updated and the result
// registered; clear, disabled-record and unused-mode words skip the select
// step. The block takes a new word only when idle, once the last word's
// update step is done. Output stall holds the last step.
// Reset (rst, synchronous, active high) empties the table and sets enable.
module hot_address_frequency_table #(
  parameter int TABLE_ENTRIES = haft_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic        compact_isa,
  input  logic [3:0]  read_rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  rank,
  output logic [31:0] entry_address,
  output logic        entry_isa,
  output logic [31:0] entry_count,
  output logic [4:0]  occupancy
);
  import haft_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

  state_t             state;
  state_t             state_next;
  logic [1:0]         cur_mode;
  logic [31:0]        cur_address;
  logic               cur_isa;
  logic [3:0]         cur_rank;
  logic               enable;
  logic [OCC_W-1:0]   occ;
  logic [OCC_W-1:0]   occ_next;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  entry_t             found;

  logic               accept_in;
  logic               out_free;
  logic               fin_go;
  logic               record_on;
  logic               saturated;
  logic [31:0]        new_count;
  cell_ctrl_t         ctrl;

  cell_link_t         link [TABLE_ENTRIES+1];
  cell_flags_t        flags [TABLE_ENTRIES];
  entry_t             entries [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] look_sel;
  logic [TABLE_ENTRIES-1:0] first_vec;
  entry_t             look_entry;
  logic [IDX_W-1:0]   look_idx;
  logic               look_any;
  logic [IDX_W-1:0]   first_idx;

  logic [2:0]         res_status;
  logic [3:0]         res_rank;
  entry_t             res_entry;

  // Handshake and shared conditions.
  assign in_stall  = (state != ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign fin_go    = (state == ST_FINISH) && out_free;
  assign record_on = (cur_mode == MODE_RECORD) && enable;
  assign saturated = hit && (found.count == COUNT_MAX);
  assign new_count = found.count + 32'd1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          if (((mode == MODE_RECORD) && enable) || (mode == MODE_READ)) begin
            state_next = ST_LOOK;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_LOOK: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Cell commands for each state.
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.addr  = cur_address;
    ctrl.isa   = cur_isa;
    ctrl.count = hit ? new_count : 32'd1;
    case (state)
      ST_IDLE: begin
        ctrl.addr = address;
        ctrl.isa  = compact_isa;
        if (accept_in) begin
          ctrl.op = CELL_CAPTURE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          if (cur_mode == MODE_CLEAR) begin
            ctrl.op = CELL_CLEAR;
          end else if (record_on) begin
            if (!hit) begin
              ctrl.op = CELL_INSERT;
            end else if (!saturated) begin
              ctrl.op = CELL_MOVE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // The row of cells.
  assign link[0] = '{entry: '0, valid: 1'b1, grp: 1'b0};

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    haft_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(k)),
      .hit_idx (hit_idx),
      .ctrl    (ctrl),
      .left    (link[k]),
      .right   (link[k+1]),
      .flags   (flags[k])
    );

    assign entries[k]   = link[k+1].entry;
    assign first_vec[k] = flags[k].first;
    assign look_sel[k]  = (cur_mode == MODE_READ) ?
                          (link[k+1].valid && (32'(cur_rank) == 32'(k))) :
                          flags[k].match;
  end

  // Matching or requested entry, registered for the final step.
  haft_pick #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_look (
    .sel     (look_sel),
    .entries (entries),
    .entry   (look_entry),
    .idx     (look_idx),
    .any     (look_any)
  );

  // New rank of a moved hit: the top cell of the moving group.
  haft_pick #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_rank (
    .sel     (first_vec),
    .entries (entries),
    .entry   (),
    .idx     (first_idx),
    .any     ()
  );

  // Result of the final step and the new fill count.
  always_comb begin
    res_status = STATUS_IGNORE;
    res_rank   = '0;
    res_entry  = '0;
    occ_next   = occ;
    case (cur_mode)
      MODE_CLEAR: begin
        res_status = STATUS_CLEAR;
        occ_next   = '0;
      end
      MODE_READ: begin
        res_status = STATUS_READ;
        res_rank   = cur_rank;
        res_entry  = found;
      end
      MODE_RECORD: begin
        if (!enable) begin
          res_status = STATUS_IGNORE;
        end else if (hit) begin
          res_status = STATUS_HIT;
          res_rank   = saturated ? 4'(hit_idx) : 4'(first_idx);
          res_entry  = '{addr: cur_address, isa: cur_isa,
                         count: saturated ? found.count : new_count};
        end else if (occ < OCC_W'(TABLE_ENTRIES)) begin
          res_status = STATUS_INSERT;
          res_rank   = 4'(occ);
          res_entry  = '{addr: cur_address, isa: cur_isa, count: 32'd1};
          occ_next   = occ + OCC_W'(1);
        end else begin
          res_status = STATUS_DROP;
        end
      end
      default: begin
        res_status = STATUS_IGNORE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      enable    <= 1'b1;
      occ       <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        enable <= cfg_wr_data;
      end
      if (state == ST_LOOK) begin
        hit <= look_any;
      end
      if (fin_go) begin
        occ       <= occ_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Captured word, lookup result and output word.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      cur_mode    <= mode;
      cur_address <= address;
      cur_isa     <= compact_isa;
      cur_rank    <= read_rank;
    end
    if (state == ST_LOOK) begin
      found   <= look_entry;
      hit_idx <= look_idx;
    end
    if (fin_go) begin
      status        <= res_status;
      rank          <= res_rank;
      entry_address <= res_entry.addr;
      entry_isa     <= res_entry.isa;
      entry_count   <= res_entry.count;
      occupancy     <= 5'(occ_next);
    end
  end

endmodule

FILE: design/haft_checker.sv
`include "assert_macros.svh"

module haft_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [3:0]  rank,
  input logic [31:0] entry_count,
  input logic [4:0]  occupancy
);
  import haft_pkg::*;

  // The block works on one word at a time.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "word accepted while busy")

  // A cleared table reports nothing.
  `ASSERT_IMPLY(a_clear_empty, clk, rst, out_valid && (status == STATUS_CLEAR), (occupancy == 5'd0) && (entry_count == 32'd0) && (rank == 4'd0), "clear result not empty")

  // An inserted entry starts at count one and sits at the end of the table.
  `ASSERT_IMPLY(a_insert_tail, clk, rst, out_valid && (status == STATUS_INSERT), (entry_count == 32'd1) && (occupancy[3:0] == rank + 4'd1), "insert not at table end")

  // A counted hit belongs to a live entry.
  `ASSERT_IMPLY(a_hit_live, clk, rst, out_valid && (status == STATUS_HIT), (entry_count != 32'd0) && (occupancy != 5'd0), "hit on empty entry")

  // A stalled result word holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(entry_count), "stalled result changed")

endmodule

bind hot_address_frequency_table haft_checker u_haft_checker (.*);

FILE: tb/hot_table_checker.sv
// Watches both channels and the enable register, keeps its own copy of the
// frequency table and compares every result word with the predicted one.
module hot_table_checker #(
  parameter int TABLE_ENTRIES = haft_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic        compact_isa,
  input  logic [3:0]  read_rank,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [3:0]  rank,
  input  logic [31:0] entry_address,
  input  logic        entry_isa,
  input  logic [31:0] entry_count,
  input  logic [4:0]  occupancy,
  output int          failures,
  output int          pending
);
  import haft_pkg::*;

  // One result word, fields in port order.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  rank;
    logic [31:0] addr;
    logic        isa;
    logic [31:0] count;
    logic [4:0]  occupancy;
  } table_report_t;

  entry_t        hot_table [TABLE_ENTRIES];
  int unsigned   used_entries;
  bit            recording_on;
  table_report_t expected_reports [$];
  table_report_t got_report;
  table_report_t want_report;
  int            mismatch_count = 0;

  initial begin
    failures = 0;
    pending = 0;
  end

  // Empty every entry.
  function automatic void clear_table();
    int k;
    for (k = 0; k < TABLE_ENTRIES; k++) begin
      hot_table[k] = '0;
    end
    used_entries = 0;
  endfunction

  // Builds a result word; entry fields only for a valid rank when asked.
  function automatic table_report_t table_report(input logic [2:0] code,
                                                 input int unsigned pos,
                                                 input bit show);
    table_report_t r;
    r = '0;
    r.status = code;
    r.rank = pos[3:0];
    if (show && pos < used_entries && pos < TABLE_ENTRIES) begin
      r.addr = hot_table[pos].addr;
      r.isa = hot_table[pos].isa;
      r.count = hot_table[pos].count;
    end
    r.occupancy = used_entries[4:0];
    return r;
  endfunction

  // Counts a hit and bubbles the entry up, or appends, or drops when full.
  function automatic table_report_t record_address(input logic [31:0] addr,
                                                   input logic isa);
    int unsigned pos;
    entry_t moved;
    for (pos = 0; pos < used_entries && pos < TABLE_ENTRIES; pos++) begin
      if (hot_table[pos].addr == addr && hot_table[pos].isa == isa) begin
        // A saturated count neither grows nor moves.
        if (hot_table[pos].count != COUNT_MAX) begin
          hot_table[pos].count = hot_table[pos].count + 32'd1;
          while (pos > 0 && hot_table[pos].count > hot_table[pos - 1].count) begin
            moved = hot_table[pos - 1];
            hot_table[pos - 1] = hot_table[pos];
            hot_table[pos] = moved;
            pos--;
          end
        end
        return table_report(STATUS_HIT, pos, 1'b1);
      end
    end
    if (used_entries < TABLE_ENTRIES) begin
      pos = used_entries;
      hot_table[pos].addr = addr;
      hot_table[pos].isa = isa;
      hot_table[pos].count = 32'd1;
      used_entries++;
      return table_report(STATUS_INSERT, pos, 1'b1);
    end
    return table_report(STATUS_DROP, 0, 1'b0);
  endfunction

  // Expected result of one accepted input word.
  function automatic table_report_t predict_word(input logic [1:0] m,
                                                 input logic [31:0] addr,
                                                 input logic isa,
                                                 input logic [3:0] rr);
    case (m)
      MODE_CLEAR: begin
        clear_table();
        return table_report(STATUS_CLEAR, 0, 1'b0);
      end
      MODE_READ: return table_report(STATUS_READ, 32'(rr), 1'b1);
      MODE_RECORD: begin
        if (recording_on) return record_address(addr, isa);
        return table_report(STATUS_IGNORE, 0, 1'b0);
      end
      default: return table_report(STATUS_IGNORE, 0, 1'b0);
    endcase
  endfunction

  task automatic log_mismatch(input string why, input table_report_t want,
                              input table_report_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected status %0d rank %0d addr %h isa %0d count %0d occ %0d",
               why, want.status, want.rank, want.addr, want.isa, want.count,
               want.occupancy);
      $display("  actual status %0d rank %0d addr %h isa %0d count %0d occ %0d",
               got.status, got.rank, got.addr, got.isa, got.count, got.occupancy);
    end
  endtask

  // Results are checked before the new word is queued, since a result can
  // never belong to a word accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      recording_on = 1'b1;
      expected_reports.delete();
    end else begin
      if (cfg_wr_en) recording_on = cfg_wr_data;
      if (out_valid && !out_stall) begin
        got_report = {status, rank, entry_address, entry_isa, entry_count, occupancy};
        if (expected_reports.size() == 0) begin
          log_mismatch("result word with nothing expected", '0, got_report);
        end else begin
          want_report = expected_reports.pop_front();
          if (got_report !== want_report) begin
            log_mismatch("result word mismatch", want_report, got_report);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_reports.push_back(predict_word(mode, address, compact_isa, read_rank));
      end
    end
    pending <= expected_reports.size();
    failures <= mismatch_count;
  end

endmodule

FILE: tb/tb_hot_address_frequency_table.sv
// Drives the frequency table with directed and random words under varying
// backpressure and reports the verdict from the checker's failure and pending counts.
module tb_hot_address_frequency_table;
  import haft_pkg::*;

  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam int          POOL_MAX       = 24;
  localparam int          LONG_HOLD      = 150;
  localparam int          SETTLE_CYCLES  = 6;
  localparam int          WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_RECORD;
  logic [31:0] address = '0;
  logic        compact_isa = 1'b0;
  logic [3:0]  read_rank = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [3:0]  rank;
  logic [31:0] entry_address;
  logic        entry_isa;
  logic [31:0] entry_count;
  logic [4:0]  occupancy;

  int          failures;
  int          pending;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] pool_addr [POOL_MAX];
  logic        pool_isa [POOL_MAX];

  always #4 clk = ~clk;

  hot_address_frequency_table DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .address       (address),
    .compact_isa   (compact_isa),
    .read_rank     (read_rank),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .rank          (rank),
    .entry_address (entry_address),
    .entry_isa     (entry_isa),
    .entry_count   (entry_count),
    .occupancy     (occupancy)
  );

  hot_table_checker table_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .address       (address),
    .compact_isa   (compact_isa),
    .read_rank     (read_rank),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .rank          (rank),
    .entry_address (entry_address),
    .entry_isa     (entry_isa),
    .entry_count   (entry_count),
    .occupancy     (occupancy),
    .failures      (failures),
    .pending       (pending)
  );

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one word after a random idle gap and holds it until accepted.
  task automatic send_word(input logic [1:0] m, input logic [31:0] a,
                           input logic isa, input logic [3:0] rr);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    compact_isa <= isa;
    read_rank <= rr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Fresh address pool; some pairs differ only in the instruction-set flag.
  task automatic fill_pool();
    int j;
    for (j = 0; j < POOL_MAX; j++) begin
      if (j > 0 && $urandom_range(3) == 0) begin
        pool_addr[j] = pool_addr[j - 1];
        pool_isa[j] = ~pool_isa[j - 1];
      end else begin
        pool_addr[j] = $urandom;
        pool_isa[j] = 1'($urandom_range(1));
      end
    end
  endtask

  // Mostly records from a skewed pool so hot entries climb the table.
  task automatic random_word(input int unsigned pool_size);
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(99);
    idx = $urandom_range($urandom_range(pool_size - 1));
    if (pick < 70) begin
      send_word(MODE_RECORD, pool_addr[idx], pool_isa[idx], 4'($urandom_range(15)));
    end else if (pick < 78) begin
      send_word(MODE_RECORD, $urandom, 1'($urandom_range(1)), 4'($urandom_range(15)));
    end else if (pick < 94) begin
      send_word(MODE_READ, $urandom, 1'($urandom_range(1)), 4'($urandom_range(15)));
    end else if (pick < 98) begin
      send_word(MODE_CLEAR, $urandom, 1'($urandom_range(1)), 4'($urandom_range(15)));
    end else begin
      send_word(MODE_UNUSED, $urandom, 1'($urandom_range(1)), 4'($urandom_range(15)));
    end
  endtask

  // One stretch of random words at a given idling mix and enable setting.
  task automatic run_phase(input int unsigned gap_pct, input int unsigned hold_pct,
                           input logic en, input int unsigned count,
                           input bit long_hold);
    int unsigned k;
    int unsigned pool_size;
    settle();
    write_enable(en);
    send_gap_pct = gap_pct;
    stall_pct <= hold_pct;
    if (long_hold) hold_requests <= hold_requests + 1;
    pool_size = $urandom_range(POOL_MAX, 4);
    fill_pool();
    for (k = 0; k < count; k++) begin
      random_word(pool_size);
    end
  endtask

  initial begin
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads of an empty table, both flags, hits that reorder.
    send_word(MODE_READ, 32'h0, 1'b0, 4'd0);
    send_word(MODE_READ, 32'hFFFF_FFFF, 1'b1, 4'd15);
    send_word(MODE_RECORD, 32'h0000_0000, 1'b0, 4'd0);
    send_word(MODE_RECORD, 32'hFFFF_FFFF, 1'b1, 4'd15);
    send_word(MODE_RECORD, 32'h0000_0000, 1'b1, 4'd0);
    send_word(MODE_RECORD, 32'hFFFF_FFFF, 1'b1, 4'd0);
    send_word(MODE_RECORD, 32'h0000_0000, 1'b1, 4'd0);
    send_word(MODE_UNUSED, 32'h1234_5678, 1'b1, 4'd9);
    send_word(MODE_READ, 32'h0, 1'b0, 4'd1);

    // Fill the table, then a drop, a hit while full and a read of the last rank.
    for (k = 0; k < 13; k++) begin
      send_word(MODE_RECORD, 32'h5A5A_0000 ^ (k << 4), k[0], 4'd0);
    end
    send_word(MODE_RECORD, 32'hDEAD_0001, 1'b0, 4'd0);
    send_word(MODE_RECORD, 32'h0000_0000, 1'b0, 4'd0);
    send_word(MODE_READ, 32'h0, 1'b0, 4'd15);
    send_word(MODE_CLEAR, 32'h0, 1'b0, 4'd0);

    // Disabled: records are ignored, other modes still work.
    settle();
    write_enable(1'b0);
    send_word(MODE_RECORD, 32'hCAFE_0000, 1'b1, 4'd0);
    send_word(MODE_READ, 32'h0, 1'b0, 4'd0);
    settle();
    write_enable(1'b1);
    send_word(MODE_RECORD, 32'hCAFE_0000, 1'b1, 4'd0);

    // Random phases with different idling on each side.
    run_phase(0, 0, 1'b1, 85, 1'b0);
    run_phase(88, 0, 1'b1, 85, 1'b0);
    run_phase(0, 88, 1'b1, 85, 1'b0);
    run_phase(21, 21, 1'b1, 85, 1'b0);
    run_phase(0, 21, 1'b0, 20, 1'b0);
    run_phase(0, 0, 1'b1, 60, 1'b1);

    settle();
    if (failures == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/haft_pkg.sv
design/haft_cell.sv
design/haft_pick.sv
design/hot_address_frequency_table.sv
design/haft_checker.sv
tb/hot_table_checker.sv
tb/tb_hot_address_frequency_table.sv
